FILE: rtl/bloom_filter_membership_defines.svh
// assertion macros for the bloom filter membership block
// no dependencies; included by files that carry concurrent assertions
`ifndef BLOOM_FILTER_MEMBERSHIP_DEFINES_SVH
`define BLOOM_FILTER_MEMBERSHIP_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge outside reset
`define BFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define BFM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BFM_ASSERT(lbl, prop, msg)

`define BFM_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/bfm_pkg.sv
// shared constants for the bloom filter membership block
// no dependencies
package bfm_pkg;

    localparam int ACTION_WIDTH = 2;
    localparam int KEY_WIDTH    = 32;
    localparam int HASH_COUNT   = 3;

    // action codes
    localparam logic [ACTION_WIDTH-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR  = 2'd2;

    // multiplier of the second hash
    localparam logic [KEY_WIDTH-1:0] HASH_MULT = 32'h045D9F3B;

    // shift amounts of the hashes
    localparam int FOLD_SHIFT  = 16;
    localparam int LEFT_SHIFT  = 6;
    localparam int RIGHT_SHIFT = 2;

endpackage

FILE: rtl/bfm_hash.sv
// three bit-index hashes of a key for the bloom filter
// depends on bfm_pkg
module bfm_hash #(
    parameter int INDEX_BITS = 10
) (
    input  logic [bfm_pkg::KEY_WIDTH-1:0]                     key,
    output logic [bfm_pkg::HASH_COUNT-1:0][INDEX_BITS-1:0]    idx
);
    import bfm_pkg::*;

    logic [KEY_WIDTH-1:0]  fold_hash;
    logic [INDEX_BITS-1:0] mult_hash;
    logic [KEY_WIDTH-1:0]  sum_hash;

    // key folded onto itself
    assign fold_hash = key ^ (key >> FOLD_SHIFT);

    // only the low index bits of the product are kept, so a narrow multiply will do
    assign mult_hash = key[INDEX_BITS-1:0] * HASH_MULT[INDEX_BITS-1:0];

    // shift-and-add hash, wraps at the key width
    assign sum_hash = key + (key << LEFT_SHIFT) + (key >> RIGHT_SHIFT);

    assign idx[0] = fold_hash[INDEX_BITS-1:0];
    assign idx[1] = mult_hash;
    assign idx[2] = sum_hash[INDEX_BITS-1:0];

endmodule

FILE: rtl/bloom_filter_membership.sv
// bloom filter membership: 2^INDEX_BITS flip-flop bit array, three hashes per key
// each beat passes through the input register and then the result register
// throughput: one beat per cycle while the output is not stalled, set by the read-modify-write of the bit array
// reset: asynchronous, clears the whole bit array and both stage valids at once
// a clear action zeroes the array in the cycle it leaves the input register
// depends on bfm_pkg, bfm_hash and bloom_filter_membership_defines.svh
`include "bloom_filter_membership_defines.svh"

module bloom_filter_membership #(
    parameter int INDEX_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bfm_pkg::ACTION_WIDTH-1:0] action,
    input  logic [bfm_pkg::KEY_WIDTH-1:0]    key,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit
);
    import bfm_pkg::*;

    localparam int FILTER_SIZE = 1 << INDEX_BITS;

    logic                                  in_valid_reg;
    logic                                  in_valid_next;
    logic [ACTION_WIDTH-1:0]               action_reg;
    logic [KEY_WIDTH-1:0]                  key_reg;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic                                  hit_reg;
    logic                                  hit_next;
    logic [FILTER_SIZE-1:0]                member_bits_reg;
    logic [FILTER_SIZE-1:0]                member_bits_next;
    logic [HASH_COUNT-1:0][INDEX_BITS-1:0] idx;
    logic                                  out_free;
    logic                                  advance;
    logic                                  in_take;

    // handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // input register
    assign in_valid_next = in_take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            key_reg    <= key;
        end
    end

    // bit indices of the registered key
    bfm_hash #(
        .INDEX_BITS (INDEX_BITS)
    ) u_hash (
        .key (key_reg),
        .idx (idx)
    );

    // bit array update and membership test
    always_comb
    begin
        member_bits_next = member_bits_reg;
        hit_next         = 1'b0;
        if (advance)
        begin
            case (action_reg)
                ACT_INSERT:
                begin
                    member_bits_next[idx[0]] = 1'b1;
                    member_bits_next[idx[1]] = 1'b1;
                    member_bits_next[idx[2]] = 1'b1;
                end
                ACT_QUERY:
                begin
                    hit_next = member_bits_reg[idx[0]] && member_bits_reg[idx[1]]
                               && member_bits_reg[idx[2]];
                end
                ACT_CLEAR:
                begin
                    member_bits_next = '0;
                end
                default:
                begin
                    member_bits_next = member_bits_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_bits_reg <= '0;
        end
        else
        begin
            member_bits_reg <= member_bits_next;
        end
    end

    // result register
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    // checks
    `BFM_ASSERT(a_result_follows, advance |=> out_valid_reg, "result beat missing after advance")
    `BFM_ASSERT(a_clear_empties, (advance && action_reg == ACT_CLEAR) |=> (member_bits_reg == '0), "array not empty after clear")
    `BFM_ASSERT(a_insert_sets, (advance && action_reg == ACT_INSERT) |=> (member_bits_reg[$past(idx[0])] && member_bits_reg[$past(idx[1])] && member_bits_reg[$past(idx[2])]), "inserted bits not set")
    `BFM_ASSERT_NEVER(a_no_stall_when_empty, in_stall && !in_valid_reg, "input stalled with empty input register")

endmodule
